// ===== rtl/core/hsva_pkg.sv =====
`default_nettype none
package hsva_pkg;

    localparam int CH_W   = 8;
    localparam int NUM_W  = 21;   // dividend width: delta << 12 or 960 * diff
    localparam int QUO_W  = 13;   // quotient bits, one per divider stage
    localparam int SIDE_W = 23;   // {grey, neg, base[12:0], v[7:0]}
    localparam int HUE_W  = 13;
    localparam int SAT_W  = 13;
    localparam int CFG_W  = 14;
    localparam int GAIN_W = 14;

    localparam logic [HUE_W-1:0] HUE_SECTOR = 13'd960;
    localparam logic [HUE_W-1:0] HUE_FULL   = 13'd5760;
    localparam logic [SAT_W-1:0] SAT_ONE    = 13'd4096;
    localparam logic [21:0]      HS_ONE     = 22'd3932160;

    localparam logic signed [CFG_W-1:0] HUE_SHIFT_MAX = 14'sd5760;
    localparam logic signed [CFG_W-1:0] HUE_SHIFT_MIN = -14'sd5760;
    localparam logic signed [CFG_W-1:0] SAT_ADJ_MAX   = 14'sd4096;
    localparam logic signed [CFG_W-1:0] SAT_ADJ_MIN   = -14'sd4096;

    // ceil(2^19 / 15), exact floor divide by 15 for values below 4096
    localparam logic [15:0] RECIP_15 = 16'd34953;

endpackage
`default_nettype wire

// ===== rtl/core/hsva_div.sv =====
`default_nettype none
// Two lockstep restoring dividers, one quotient bit per stage.
module hsva_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [hsva_pkg::NUM_W-1:0]    num_a,
    input  wire logic [hsva_pkg::CH_W-1:0]     den_a,
    input  wire logic [hsva_pkg::NUM_W-1:0]    num_b,
    input  wire logic [hsva_pkg::CH_W-1:0]     den_b,
    input  wire logic [hsva_pkg::SIDE_W-1:0]   side_in,
    output logic                               out_valid,
    output logic [hsva_pkg::QUO_W-1:0]         q_a,
    output logic [hsva_pkg::QUO_W-1:0]         q_b,
    output logic [hsva_pkg::SIDE_W-1:0]        side_out
);
    import hsva_pkg::*;

    logic [QUO_W-1:0]  vld_reg;
    logic [NUM_W-1:0]  rema_reg [QUO_W];
    logic [NUM_W-1:0]  remb_reg [QUO_W];
    logic [CH_W-1:0]   dena_reg [QUO_W];
    logic [CH_W-1:0]   denb_reg [QUO_W];
    logic [QUO_W-1:0]  qa_reg   [QUO_W];
    logic [QUO_W-1:0]  qb_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    logic [NUM_W-1:0]  rema_in  [QUO_W];
    logic [NUM_W-1:0]  remb_in  [QUO_W];
    logic [CH_W-1:0]   dena_in  [QUO_W];
    logic [CH_W-1:0]   denb_in  [QUO_W];
    logic [QUO_W-1:0]  qa_in    [QUO_W];
    logic [QUO_W-1:0]  qb_in    [QUO_W];
    logic [SIDE_W-1:0] side_in_s[QUO_W];
    logic [NUM_W-1:0]  dsha     [QUO_W];
    logic [NUM_W-1:0]  dshb     [QUO_W];
    logic [NUM_W-1:0]  rema_next[QUO_W];
    logic [NUM_W-1:0]  remb_next[QUO_W];
    logic [QUO_W-1:0]  qa_next  [QUO_W];
    logic [QUO_W-1:0]  qb_next  [QUO_W];

    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            if (k == 0) begin
                rema_in[k]   = num_a;
                remb_in[k]   = num_b;
                dena_in[k]   = den_a;
                denb_in[k]   = den_b;
                qa_in[k]     = '0;
                qb_in[k]     = '0;
                side_in_s[k] = side_in;
            end else begin
                rema_in[k]   = rema_reg[k-1];
                remb_in[k]   = remb_reg[k-1];
                dena_in[k]   = dena_reg[k-1];
                denb_in[k]   = denb_reg[k-1];
                qa_in[k]     = qa_reg[k-1];
                qb_in[k]     = qb_reg[k-1];
                side_in_s[k] = side_reg[k-1];
            end
            // stage k resolves quotient bit QUO_W-1-k
            dsha[k] = NUM_W'(dena_in[k]) << (QUO_W - 1 - k);
            dshb[k] = NUM_W'(denb_in[k]) << (QUO_W - 1 - k);
            if (rema_in[k] >= dsha[k]) begin
                rema_next[k] = rema_in[k] - dsha[k];
                qa_next[k]   = {qa_in[k][QUO_W-2:0], 1'b1};
            end else begin
                rema_next[k] = rema_in[k];
                qa_next[k]   = {qa_in[k][QUO_W-2:0], 1'b0};
            end
            if (remb_in[k] >= dshb[k]) begin
                remb_next[k] = remb_in[k] - dshb[k];
                qb_next[k]   = {qb_in[k][QUO_W-2:0], 1'b1};
            end else begin
                remb_next[k] = remb_in[k];
                qb_next[k]   = {qb_in[k][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QUO_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QUO_W; k++) begin
                rema_reg[k] <= rema_next[k];
                remb_reg[k] <= remb_next[k];
                dena_reg[k] <= dena_in[k];
                denb_reg[k] <= denb_in[k];
                qa_reg[k]   <= qa_next[k];
                qb_reg[k]   <= qb_next[k];
                side_reg[k] <= side_in_s[k];
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign q_a       = qa_reg[QUO_W-1];
    assign q_b       = qb_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule
`default_nettype wire

// ===== rtl/core/hsva_hsv2rgb.sv =====
`default_nettype none
// Hue/saturation adjust and HSV to RGB conversion, five register stages.
module hsva_hsv2rgb (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire logic [hsva_pkg::QUO_W-1:0]         q_sat,
    input  wire logic [hsva_pkg::QUO_W-1:0]         q_hue,
    input  wire logic [hsva_pkg::SIDE_W-1:0]        side,
    input  wire logic                               op_sat,
    input  wire logic signed [hsva_pkg::CFG_W-1:0]  hue_shift,
    input  wire logic [hsva_pkg::GAIN_W-1:0]        gain,
    output logic                                    out_valid,
    output logic [hsva_pkg::CH_W-1:0]               red,
    output logic [hsva_pkg::CH_W-1:0]               green,
    output logic [hsva_pkg::CH_W-1:0]               blue
);
    import hsva_pkg::*;

    logic [4:0] vld_reg;

    // stage 1: hue assembly, hue rotate, saturation gain product
    logic [CH_W-1:0]  v0;
    logic [HUE_W-1:0] base0;
    logic             neg0;
    logic             grey0;
    logic [HUE_W-1:0] h0;
    logic [SAT_W-1:0] s0;
    logic signed [14:0] hsum;
    logic [HUE_W-1:0] h1;
    logic [HUE_W-1:0] b1_h_reg;
    logic [SAT_W-1:0] b1_s_reg;
    logic [26:0]      b1_prod_reg;
    logic             b1_op_reg;
    logic [CH_W-1:0]  b1_v_reg;

    assign v0    = side[CH_W-1:0];
    assign base0 = side[CH_W+HUE_W-1:CH_W];
    assign neg0  = side[CH_W+HUE_W];
    assign grey0 = side[CH_W+HUE_W+1];

    always_comb begin
        if (grey0) begin
            h0 = '0;
            s0 = '0;
        end else begin
            h0 = neg0 ? (base0 - q_hue) : (base0 + q_hue);
            s0 = q_sat;
        end
        hsum = $signed({2'b00, h0}) + $signed({hue_shift[CFG_W-1], hue_shift});
        if (hsum < 0) begin
            h1 = HUE_W'(hsum + $signed({2'b00, HUE_FULL}));
        end else if (hsum >= $signed({2'b00, HUE_FULL})) begin
            h1 = HUE_W'(hsum - $signed({2'b00, HUE_FULL}));
        end else begin
            h1 = HUE_W'(hsum);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_h_reg    <= op_sat ? h0 : h1;
            b1_s_reg    <= s0;
            b1_prod_reg <= 27'(s0) * 27'(gain);
            b1_op_reg   <= op_sat;
            b1_v_reg    <= v0;
        end
    end

    // stage 2: saturation clamp, sector split
    logic [13:0]      sc;
    logic [SAT_W-1:0] s2;
    logic [2:0]       i2;
    logic [HUE_W-1:0] ofs2;
    logic [SAT_W-1:0] b2_s_reg;
    logic [2:0]       b2_i_reg;
    logic [9:0]       b2_f_reg;
    logic [CH_W-1:0]  b2_v_reg;

    always_comb begin
        sc = b1_prod_reg[25:12];
        if (!b1_op_reg) begin
            s2 = b1_s_reg;
        end else if (sc > 14'(SAT_ONE)) begin
            s2 = SAT_ONE;
        end else begin
            s2 = SAT_W'(sc);
        end
        if (b1_h_reg >= 13'd4800) begin
            i2 = 3'd5; ofs2 = 13'd4800;
        end else if (b1_h_reg >= 13'd3840) begin
            i2 = 3'd4; ofs2 = 13'd3840;
        end else if (b1_h_reg >= 13'd2880) begin
            i2 = 3'd3; ofs2 = 13'd2880;
        end else if (b1_h_reg >= 13'd1920) begin
            i2 = 3'd2; ofs2 = 13'd1920;
        end else if (b1_h_reg >= HUE_SECTOR) begin
            i2 = 3'd1; ofs2 = HUE_SECTOR;
        end else begin
            i2 = 3'd0; ofs2 = 13'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b2_s_reg <= s2;
            b2_i_reg <= i2;
            b2_f_reg <= 10'(b1_h_reg - ofs2);
            b2_v_reg <= b1_v_reg;
        end
    end

    // stage 3: s*f, s*(960-f), v*(1-s)
    logic [21:0]     b3_sf_reg;
    logic [21:0]     b3_st_reg;
    logic [20:0]     b3_pp_reg;
    logic [2:0]      b3_i_reg;
    logic            b3_zero_reg;
    logic [CH_W-1:0] b3_v_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            b3_sf_reg   <= 22'(b2_s_reg) * 22'(b2_f_reg);
            b3_st_reg   <= 22'(b2_s_reg) * 22'(HUE_SECTOR[9:0] - b2_f_reg);
            b3_pp_reg   <= 21'(b2_v_reg) * 21'(SAT_ONE - b2_s_reg);
            b3_i_reg    <= b2_i_reg;
            b3_zero_reg <= (b2_s_reg == '0);
            b3_v_reg    <= b2_v_reg;
        end
    end

    // stage 4: v * (1 - s*f) products
    logic [29:0]     b4_pq_reg;
    logic [29:0]     b4_pt_reg;
    logic [CH_W-1:0] b4_p_reg;
    logic [2:0]      b4_i_reg;
    logic            b4_zero_reg;
    logic [CH_W-1:0] b4_v_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            b4_pq_reg   <= 30'(b3_v_reg) * 30'(HS_ONE - b3_sf_reg);
            b4_pt_reg   <= 30'(b3_v_reg) * 30'(HS_ONE - b3_st_reg);
            b4_p_reg    <= b3_pp_reg[19:12];
            b4_i_reg    <= b3_i_reg;
            b4_zero_reg <= b3_zero_reg;
            b4_v_reg    <= b3_v_reg;
        end
    end

    // stage 5: divide by 960*4096 = shift by 18, then by 15 via reciprocal
    logic [27:0]     mq;
    logic [27:0]     mt;
    logic [CH_W-1:0] q5;
    logic [CH_W-1:0] t5;
    logic [CH_W-1:0] r5;
    logic [CH_W-1:0] g5;
    logic [CH_W-1:0] bl5;
    logic [CH_W-1:0] red_reg;
    logic [CH_W-1:0] green_reg;
    logic [CH_W-1:0] blue_reg;

    always_comb begin
        mq = 28'(b4_pq_reg[29:18]) * 28'(RECIP_15);
        mt = 28'(b4_pt_reg[29:18]) * 28'(RECIP_15);
        q5 = mq[26:19];
        t5 = mt[26:19];
        if (b4_zero_reg) begin
            r5 = b4_v_reg; g5 = b4_v_reg; bl5 = b4_v_reg;
        end else begin
            case (b4_i_reg)
                3'd0: begin r5 = b4_v_reg; g5 = t5;       bl5 = b4_p_reg; end
                3'd1: begin r5 = q5;       g5 = b4_v_reg; bl5 = b4_p_reg; end
                3'd2: begin r5 = b4_p_reg; g5 = b4_v_reg; bl5 = t5;       end
                3'd3: begin r5 = b4_p_reg; g5 = q5;       bl5 = b4_v_reg; end
                3'd4: begin r5 = t5;       g5 = b4_p_reg; bl5 = b4_v_reg; end
                default: begin r5 = b4_v_reg; g5 = b4_p_reg; bl5 = q5;    end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg   <= r5;
            green_reg <= g5;
            blue_reg  <= bl5;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    assign out_valid = vld_reg[4];
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule
`default_nettype wire

// ===== rtl/core/hsv_hue_saturation_adjust.sv =====
`default_nettype none
// Per-pixel hue rotation or saturation scaling of an 8-bit RGB stream.
// Input stream s_*: one pixel per transaction, s_tdata = {blue, green, red}.
// Output stream m_*: adjusted pixel, same packing, one result per input.
// APB port: reg 0 (addr 0x0) operation, 0 = hue rotate, 1 = saturation scale;
//   reg 1 (0x4) hue_shift, signed 1/16 degree; reg 2 (0x8) saturation_adjust,
//   signed Q12. Write only while the stream is idle.
// Pipeline: m_tvalid follows the input transaction through 20 register
//   stages: 1 front stage, 13 divider stages, 5 back-conversion stages,
//   1 output register.
// Throughput: one pixel per cycle while the skid register is empty; the hue and saturation quotients come
//   from two restoring dividers pipelined at one bit per stage.
// Stall: a skid register behind the output register catches the item that
//   is in flight when m_tready drops; the pipeline then freezes and s_tready
//   goes low until the skid drains. Nothing is lost or repeated.
// Reset (aresetn low, synchronous): all valid bits and config registers clear; data registers are not reset.
module hsv_hue_saturation_adjust (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import hsva_pkg::*;

    localparam logic [1:0] REG_OPERATION = 2'd0;
    localparam logic [1:0] REG_HUE_SHIFT = 2'd1;
    localparam logic [1:0] REG_SAT_ADJ   = 2'd2;

    // configuration
    logic                    op_reg;
    logic signed [CFG_W-1:0] hue_shift_reg;
    logic signed [CFG_W-1:0] sat_adj_reg;
    logic                    cfg_wr;
    logic signed [CFG_W-1:0] shift_c;
    logic signed [CFG_W-1:0] adj_c;
    logic [GAIN_W-1:0]       gain;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg        <= 1'b0;
            hue_shift_reg <= '0;
            sat_adj_reg   <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_OPERATION: op_reg        <= pwdata[0];
                REG_HUE_SHIFT: hue_shift_reg <= pwdata[CFG_W-1:0];
                REG_SAT_ADJ:   sat_adj_reg   <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_OPERATION: prdata = {31'd0, op_reg};
            REG_HUE_SHIFT: prdata = {18'd0, hue_shift_reg};
            REG_SAT_ADJ:   prdata = {18'd0, sat_adj_reg};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        if (hue_shift_reg > HUE_SHIFT_MAX) begin
            shift_c = HUE_SHIFT_MAX;
        end else if (hue_shift_reg < HUE_SHIFT_MIN) begin
            shift_c = HUE_SHIFT_MIN;
        end else begin
            shift_c = hue_shift_reg;
        end
        if (sat_adj_reg > SAT_ADJ_MAX) begin
            adj_c = SAT_ADJ_MAX;
        end else if (sat_adj_reg < SAT_ADJ_MIN) begin
            adj_c = SAT_ADJ_MIN;
        end else begin
            adj_c = sat_adj_reg;
        end
        gain = GAIN_W'(adj_c + $signed({1'b0, SAT_ONE}));
    end

    // pipeline advance; frozen while the skid register is full
    logic skid_vld_reg;
    logic en;

    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // front stage: max, min, delta, sector base, dividends
    logic [CH_W-1:0]   r_in;
    logic [CH_W-1:0]   g_in;
    logic [CH_W-1:0]   b_in;
    logic [CH_W-1:0]   mx;
    logic [CH_W-1:0]   mn;
    logic [CH_W-1:0]   delta;
    logic [CH_W-1:0]   diff;
    logic [HUE_W-1:0]  base;
    logic              neg;
    logic              f_vld_reg;
    logic [NUM_W-1:0]  f_num_sat_reg;
    logic [NUM_W-1:0]  f_num_hue_reg;
    logic [CH_W-1:0]   f_mx_reg;
    logic [CH_W-1:0]   f_delta_reg;
    logic [SIDE_W-1:0] f_side_reg;

    assign r_in = s_tdata[7:0];
    assign g_in = s_tdata[15:8];
    assign b_in = s_tdata[23:16];

    always_comb begin
        mx = r_in;
        mn = r_in;
        if (g_in > mx) mx = g_in;
        if (b_in > mx) mx = b_in;
        if (g_in < mn) mn = g_in;
        if (b_in < mn) mn = b_in;
        delta = mx - mn;
        if (r_in == mx) begin
            neg  = (g_in < b_in);
            diff = neg ? (b_in - g_in) : (g_in - b_in);
            base = neg ? HUE_FULL : 13'd0;
        end else if (g_in == mx) begin
            neg  = (b_in < r_in);
            diff = neg ? (r_in - b_in) : (b_in - r_in);
            base = 13'd1920;
        end else begin
            neg  = (r_in < g_in);
            diff = neg ? (g_in - r_in) : (r_in - g_in);
            base = 13'd3840;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
        end else if (en) begin
            f_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_num_sat_reg <= {1'b0, delta, 12'd0};
            // 960 * diff = (diff << 10) - (diff << 6)
            f_num_hue_reg <= (NUM_W'(diff) << 10) - (NUM_W'(diff) << 6);
            f_mx_reg      <= mx;
            f_delta_reg   <= delta;
            f_side_reg    <= {(delta == '0), neg, base, mx};
        end
    end

    // dividers
    logic              d_vld;
    logic [QUO_W-1:0]  d_q_sat;
    logic [QUO_W-1:0]  d_q_hue;
    logic [SIDE_W-1:0] d_side;

    hsva_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_vld_reg),
        .num_a     (f_num_sat_reg),
        .den_a     (f_mx_reg),
        .num_b     (f_num_hue_reg),
        .den_b     (f_delta_reg),
        .side_in   (f_side_reg),
        .out_valid (d_vld),
        .q_a       (d_q_sat),
        .q_b       (d_q_hue),
        .side_out  (d_side)
    );

    // adjust and back conversion
    logic            c_vld;
    logic [CH_W-1:0] c_red;
    logic [CH_W-1:0] c_green;
    logic [CH_W-1:0] c_blue;

    hsva_hsv2rgb u_hsv2rgb (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_vld),
        .q_sat     (d_q_sat),
        .q_hue     (d_q_hue),
        .side      (d_side),
        .op_sat    (op_reg),
        .hue_shift (shift_c),
        .gain      (gain),
        .out_valid (c_vld),
        .red       (c_red),
        .green     (c_green),
        .blue      (c_blue)
    );

    // output register plus skid
    logic        out_vld_reg;
    logic [23:0] out_data_reg;
    logic [23:0] skid_data_reg;
    logic        out_free;

    assign out_free = !out_vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (out_free) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
        end else if (c_vld) begin
            if (out_free) begin
                out_vld_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (out_free) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (out_free) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (c_vld) begin
            if (out_free) begin
                out_data_reg <= {c_blue, c_green, c_red};
            end else begin
                skid_data_reg <= {c_blue, c_green, c_red};
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire
